FILE: src/rmst_pkg.sv
// Package for the range-minimum segment tree.
// Holds request codes, key constants and the per-level cell interface type.
`timescale 1ns / 1ps
package rmst_pkg;
  localparam logic REQ_SET   = 1'b0;
  localparam logic REQ_QUERY = 1'b1;
  localparam logic [31:0] KEY_MAX   = 32'hFFFF_FFFF;
  localparam logic [31:0] SIGN_FLIP = 32'h8000_0000;

  typedef struct packed {
    logic        vld;
    logic        is_query;
    logic [16:0] lo;     // level-local left node offset
    logic [16:0] hi;     // level-local right node offset
    logic        empty;  // climb finished
    logic [31:0] best;   // running minimum key or set key
  } lvl_tok_t;
endpackage

FILE: src/rmst_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module rmst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

FILE: src/rmst_cell.sv
// One tree level: holds its nodes in a RAM that is cleared after reset, and
// takes one token at a time from the level below, only while idle. Depends on rmst_pkg, rmst_ram.
`timescale 1ns / 1ps
module rmst_cell
  import rmst_pkg::*;
#(
  parameter int AW = 4   // node address bits at this level (>=1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          clr,
  input  logic [AW-1:0] clr_addr,
  input  lvl_tok_t      tin,
  // set path: tout carries the written key's minimum with its sibling upward
  output lvl_tok_t      tout,
  output logic          done
);
  localparam int N = 1 << AW;
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001, S_RD0 = 5'b00010, S_RD1 = 5'b00100,
    S_RD2 = 5'b01000, S_OUT = 5'b10000
  } st_t;
  st_t st;
  lvl_tok_t t;
  logic [AW-1:0] addr;
  logic we;
  logic [31:0] wdata, rdata, rkey;

  rmst_ram #(.WIDTH(32), .DEPTH(N)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  // clear: fill with the largest key
  // set: write key at lo, read sibling lo^1; query: read lo then hi
  always_comb begin
    we = 1'b0; wdata = t.best; addr = t.lo[AW-1:0];
    if (clr) begin
      we = 1'b1; wdata = KEY_MAX; addr = clr_addr;
    end else begin
      case (st)
        S_RD0: begin
          if (!t.is_query) we = 1'b1;
          if (t.is_query) addr = t.lo[AW-1:0];
        end
        S_RD1: addr = t.is_query ? t.hi[AW-1:0] : (t.lo[AW-1:0] ^ AW'(1));
        default: ;
      endcase
    end
  end

  assign rkey = rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE; tout <= '0; done <= 1'b0;
    end else begin
      tout.vld <= st == S_OUT;
      done <= st == S_OUT;
      case (st)
        S_IDLE: if (tin.vld) begin
          t <= tin; st <= S_RD0;
        end
        S_RD0: begin
          st <= S_RD1;
        end
        S_RD1: begin
          // lo read returns now for query
          if (t.is_query && !t.empty && t.lo[0])
            t.best <= (rkey < t.best) ? rkey : t.best;
          st <= S_RD2;
        end
        S_RD2: begin
          if (t.is_query) begin
            if (!t.empty && !t.hi[0] && !(t.lo[0] && t.lo == t.hi))
              t.best <= (rkey < t.best) ? rkey : t.best;
          end else begin
            t.best <= (rkey < t.best) ? rkey : t.best;
          end
          st <= S_OUT;
        end
        S_OUT: begin
          tout.is_query <= t.is_query;
          tout.best     <= t.best;
          if (t.is_query) begin
            tout.lo    <= {1'b0, t.lo[16:1]} + {16'd0, t.lo[0]};
            tout.hi    <= {1'b0, t.hi[16:1]} - {16'd0, ~t.hi[0]};
            tout.empty <= t.empty ||
              (({1'b0, t.lo} + {17'd0, t.lo[0]}) > ({1'b0, t.hi} - {17'd0, ~t.hi[0]})) ||
              (!t.hi[0] && t.hi == 17'd0);
          end else begin
            tout.lo    <= {1'b0, t.lo[16:1]};
            tout.hi    <= '0;
            tout.empty <= 1'b0;
          end
          st <= S_IDLE;
        end
        default: st <= S_IDLE;
      endcase
    end
  end
endmodule

FILE: src/rmst_root.sv
// Root node register at the top of the cell chain.
// Depends on rmst_pkg.
`timescale 1ns / 1ps
module rmst_root
  import rmst_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  lvl_tok_t    tin,
  output logic        strobe,
  output logic [31:0] min_key,
  output logic        done
);
  logic [31:0] root;
  always_ff @(posedge clk) begin
    if (rst) begin
      root <= KEY_MAX; strobe <= 1'b0; done <= 1'b0;
    end else begin
      strobe <= tin.vld && tin.is_query;
      done <= tin.vld;
      if (tin.vld) begin
        if (tin.is_query) begin
          min_key <= (!tin.empty && tin.best > root) ? root : tin.best;
        end else begin
          root <= tin.best;
        end
      end
    end
  end
endmodule

FILE: src/range_min_segment_tree_top.sv
// Top level of the range-minimum segment tree: request decode, the chain
// of level cells and the root register. Depends on rmst_pkg and its cells.
//
// Usage: drive req_type, left_index, right_index and value with start high
// while busy is low; that edge accepts the transaction. A set writes the
// leaf and carries the child minimum up through one cell per level. A query
// climbs both range ends through the same cells and raises done for one
// cycle with min_value. Each cell steps through S_RD0, S_RD1, S_RD2 and S_OUT
// on a transaction (one port of its level RAM, two reads), so a request passes
// every cell in turn; busy holds one request at a time. Sets give no strobe.
// Reset starts a clearing pass that writes the largest value into every node
// of all levels in parallel, one address per cycle; busy stays high until it
// ends. The receiver cannot stall: done lasts exactly one cycle.
`timescale 1ns / 1ps
module range_min_segment_tree_top
  import rmst_pkg::*;
#(
  parameter int LEAVES = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               req_type,
  input  logic [10:0]        left_index,
  input  logic [10:0]        right_index,
  input  logic signed [31:0] value,
  output logic               done,
  output logic signed [31:0] min_value
);
  localparam int LV = (LEAVES <= 2) ? 1 : $clog2(LEAVES);
  localparam logic [16:0] LMAX = 17'(LEAVES);

  lvl_tok_t tok [LV+1];
  logic [LV:0] lv_done;
  logic root_done, strobe;
  logic [31:0] min_key;
  logic [16:0] lp, rp;
  logic set_ok;
  logic clearing;
  logic [LV-1:0] clr_addr;

  always_comb begin
    lp = {6'd0, left_index};
    rp = {6'd0, right_index};
    if (lp < 17'd1) lp = 17'd1;
    if (rp > LMAX) rp = LMAX;
    set_ok = left_index != 11'd0 && {6'd0, left_index} <= LMAX;
  end

  // walk every node address once after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1; clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + LV'(1);
      clearing <= clr_addr != '1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1; tok[0] <= '0;
    end else begin
      tok[0].vld <= start && !busy && (req_type == REQ_QUERY || set_ok);
      if (start && !busy) begin
        if (req_type == REQ_QUERY || set_ok) begin
          busy <= 1'b1;
          tok[0].is_query <= req_type == REQ_QUERY;
          tok[0].best     <= (req_type == REQ_QUERY) ? KEY_MAX
                             : (value ^ SIGN_FLIP);
          tok[0].lo <= ((req_type == REQ_QUERY) ? lp : {6'd0, left_index}) - 17'd1;
          tok[0].hi <= rp - 17'd1;
          tok[0].empty <= (req_type == REQ_QUERY) && (lp > rp);
        end
      end else if (clearing) begin
        busy <= clr_addr != '1;
      end else if (root_done) begin
        busy <= 1'b0;
      end
    end
  end

  for (genvar g = 0; g < LV; g++) begin : g_lvl
    rmst_cell #(.AW(LV - g)) u_cell (
      .clk(clk), .rst(rst), .clr(clearing), .clr_addr(clr_addr[LV-g-1:0]),
      .tin(tok[g]), .tout(tok[g+1]), .done(lv_done[g])
    );
  end
  assign lv_done[LV] = 1'b0;

  rmst_root u_root (
    .clk(clk), .rst(rst), .tin(tok[LV]), .strobe(strobe),
    .min_key(min_key), .done(root_done)
  );

  assign done = strobe;
  assign min_value = signed'(min_key ^ SIGN_FLIP);

`ifndef NO_ASSERTIONS
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("result without a request in flight");
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    $countones(lv_done) <= 1) else $error("two levels active at once");
  a_release: assert property (@(posedge clk) disable iff (rst)
    root_done |=> !busy) else $error("busy held after request finished");
`endif
endmodule

FILE: bench/range_min_segment_tree_top_tb.sv
// Testbench for range_min_segment_tree_top: set and query transactions checked
// against a shadow array scanned directly in the bench. Depends on rmst_pkg and the top.
`timescale 1ns / 1ps
module range_min_segment_tree_top_tb;
  import rmst_pkg::*;

  localparam int LEAVES = 1024;
  localparam int SETTLE = 80;

  typedef struct packed {
    logic               kind;
    logic [10:0]        lpos;
    logic [10:0]        rpos;
    logic signed [31:0] val;
  } request_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic               req_type = REQ_SET;
  logic [10:0]        left_index = '0;
  logic [10:0]        right_index = '0;
  logic signed [31:0] value = '0;
  logic               done;
  logic signed [31:0] min_value;

  range_min_segment_tree_top #(.LEAVES(LEAVES)) uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req_type(req_type),
    .left_index(left_index), .right_index(right_index), .value(value),
    .done(done), .min_value(min_value)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  request_t           pending_reqs[$];
  logic signed [31:0] expected_mins[$];
  logic signed [31:0] shadow[1:LEAVES];
  int                 idle_pct = 0;
  int                 mismatches = 0;
  int                 n_sets = 0;
  int                 n_queries = 0;
  int                 n_mins = 0;

  // Direct scan over the clamped range; independent of the tree walk.
  function automatic logic signed [31:0] scan_min(input request_t r);
    logic signed [31:0] m;
    int lo;
    int hi;
    m = 32'sh7FFF_FFFF;
    lo = (r.lpos < 11'd1) ? 1 : int'(r.lpos);
    hi = (r.rpos > 11'(LEAVES)) ? LEAVES : int'(r.rpos);
    for (int p = lo; p <= hi; p++)
      if (shadow[p] < m) m = shadow[p];
    return m;
  endfunction

  // Driver: predict at acceptance, then hold or advance.
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) begin
        if (req_type == REQ_QUERY) begin
          expected_mins.push_back(scan_min({req_type, left_index, right_index, value}));
          n_queries++;
        end else begin
          if (left_index >= 1 && left_index <= LEAVES) shadow[left_index] = value;
          n_sets++;
        end
        void'(pending_reqs.pop_front());
      end
      if (start && busy) begin
        // hold the transaction until it is taken
      end else if (pending_reqs.size() > (start && !busy ? 0 : 0) &&
                   $urandom_range(99) >= idle_pct) begin
        start       <= 1'b1;
        req_type    <= pending_reqs[0].kind;
        left_index  <= pending_reqs[0].lpos;
        right_index <= pending_reqs[0].rpos;
        value       <= pending_reqs[0].val;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_mins.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result min_value=%0d", min_value);
      end else begin
        if (min_value !== expected_mins[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("min_value mismatch: expected %0d got %0d", expected_mins[0], min_value);
        end
        void'(expected_mins.pop_front());
        n_mins++;
      end
    end
  end

  function automatic request_t rand_req();
    request_t r;
    int a;
    int b;
    r.kind = $urandom_range(99) < 45 ? REQ_QUERY : REQ_SET;
    case ($urandom_range(9))
      0:       begin a = $urandom_range(2047); b = $urandom_range(2047); end
      1:       begin a = $urandom_range(1, LEAVES); b = a; end
      2, 3:    begin a = $urandom_range(1, LEAVES); b = a + $urandom_range(15); end
      default: begin a = $urandom_range(1, LEAVES); b = $urandom_range(1, LEAVES); end
    endcase
    if (r.kind == REQ_QUERY && a > b && $urandom_range(3) != 0) begin
      int t;
      t = a; a = b; b = t;
    end
    r.lpos = a[10:0];
    r.rpos = b > 2047 ? 11'd2047 : b[10:0];
    case ($urandom_range(7))
      0:       r.val = 32'sh8000_0000;
      1:       r.val = 32'sh7FFF_FFFF;
      2:       r.val = $signed($urandom_range(200)) - 100;
      default: r.val = $signed($urandom);
    endcase
    return r;
  endfunction

  task automatic push(input logic k, input int l, input int h, input logic signed [31:0] v);
    pending_reqs.push_back({k, l[10:0], h[10:0], v});
  endtask

  task automatic drain();
    while (pending_reqs.size() != 0 || start || busy || expected_mins.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin
    int phase_pct[4] = '{0, 50, 0, 13};
    for (int p = 1; p <= LEAVES; p++) shadow[p] = 32'sh7FFF_FFFF;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    // Directed: empty tree, extremes, out-of-range sets, clamped and empty queries.
    push(REQ_QUERY, 1, LEAVES, 0);
    push(REQ_SET, 1, 0, 32'sh8000_0000);
    push(REQ_SET, LEAVES, 0, 32'sh7FFF_FFFE);
    push(REQ_SET, 0, 0, -5);
    push(REQ_SET, LEAVES + 1, 0, -6);
    push(REQ_SET, 2047, 2047, -7);
    push(REQ_QUERY, 0, 2047, 0);
    push(REQ_QUERY, 2, LEAVES, 0);
    push(REQ_QUERY, LEAVES, LEAVES, 0);
    push(REQ_QUERY, LEAVES, 2047, 0);
    push(REQ_QUERY, 5, 4, 0);
    push(REQ_QUERY, 0, 0, 0);
    push(REQ_QUERY, 2047, 2047, 0);
    push(REQ_SET, 512, 0, 32'shFFFF_FFFF);
    push(REQ_SET, 513, 0, 32'sh5555_5555);
    push(REQ_SET, 1365, 1365, 32'shAAAA_AAAA);
    push(REQ_QUERY, 511, 514, 32'shFFFF_FFFF);
    push(REQ_QUERY, 513, 513, 0);
    push(REQ_QUERY, 1365, 682, 0);
    push(REQ_SET, 1, 0, 0);
    push(REQ_QUERY, 1, 2, 0);
    drain();
    // Random phases; drain between them so the sender pauses for all results.
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = phase_pct[ph];
      repeat (435) pending_reqs.push_back(rand_req());
      drain();
    end
    $display("covered %0d sets and %0d queries, %0d minima checked over four idle phases",
             n_sets, n_queries, n_mins);
    if (mismatches == 0 && expected_mins.size() == 0) begin
      $display("range_min_segment_tree_top_tb passed");
    end else begin
      $display("range_min_segment_tree_top_tb failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("range_min_segment_tree_top_tb failed");
    $finish;
  end
endmodule

FILE: filelist.f
src/rmst_pkg.sv
src/rmst_ram.sv
src/rmst_cell.sv
src/rmst_root.sv
src/range_min_segment_tree_top.sv
bench/range_min_segment_tree_top_tb.sv
